[hdl/ftf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftf_pkg: shared types and constants for the face tangent frame block.
// Holds field widths, fixed-point formats and the payload structs.
// ----------------------------------------------------------------------------
package ftf_pkg;

	localparam int unsigned CoordWidth  = 32;
	localparam int unsigned OutFracBits = 14;
	localparam int unsigned NormBits    = 24;
	localparam int unsigned DiffWidth   = CoordWidth + 1;
	localparam int unsigned ProdWidth   = 2 * DiffWidth;
	localparam int unsigned VecWidth    = ProdWidth + 1;
	localparam int unsigned MagWidth    = VecWidth;
	localparam int unsigned ShiftWidth  = $clog2(MagWidth + 1);
	localparam int unsigned SumWidth    = 2 * NormBits + 2;
	localparam int unsigned RadWidth    = SumWidth + 12;
	localparam int unsigned RootWidth   = (RadWidth + 1) / 2;
	localparam int unsigned NumerWidth  = NormBits + OutFracBits + 6;
	localparam int unsigned QuotWidth   = NumerWidth;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [15:0]           unit_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t tex_u;
		coord_t tex_v;
	} vertex_t;

	typedef struct packed {
		unit_t tangent_x;
		unit_t tangent_y;
		unit_t tangent_z;
		unit_t binormal_x;
		unit_t binormal_y;
		unit_t binormal_z;
		unit_t normal_x;
		unit_t normal_y;
		unit_t normal_z;
	} frame_t;

endpackage

[hdl/ftf_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftf_vertex_if / ftf_frame_if: valid-ready channels of the block.
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface ftf_vertex_if;
	logic             valid;
	logic             ready;
	ftf_pkg::vertex_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ftf_frame_if;
	logic            valid;
	logic            ready;
	ftf_pkg::frame_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/ftf_norm_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftf_norm_unit: iterative normalizer for one wide signed 3-vector.
// Scales to 24 bits, sums squares with one multiplier, takes a bit-serial
// square root and forms three rounded quotients with a restoring divider.
// ----------------------------------------------------------------------------
module ftf_norm_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ftf_pkg::VecWidth-1:0] vec_x,
	input  logic signed [ftf_pkg::VecWidth-1:0] vec_y,
	input  logic signed [ftf_pkg::VecWidth-1:0] vec_z,
	output logic                                done,
	output ftf_pkg::unit_t                      out_x,
	output ftf_pkg::unit_t                      out_y,
	output ftf_pkg::unit_t                      out_z
);

	localparam int unsigned MW = ftf_pkg::MagWidth;
	localparam int unsigned NB = ftf_pkg::NormBits;
	localparam int unsigned SW = ftf_pkg::SumWidth;
	localparam int unsigned RW = ftf_pkg::RadWidth;
	localparam int unsigned QW = ftf_pkg::RootWidth;
	localparam int unsigned DW = ftf_pkg::NumerWidth;
	localparam int unsigned CW = $clog2(DW + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SHIFT = 7'b0000010,
		S_SQ    = 7'b0000100,
		S_ROOT  = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_SAT   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [MW-1:0]           mag_q [3];
	logic [2:0]              neg_q;
	logic [NB-1:0]           c_q [3];
	logic [SW-1:0]           sum_q;
	logic [RW-1:0]           rem_q;
	logic [RW-1:0]           root_q;
	logic [RW-1:0]           rbit_q;
	logic [1:0]              idx_q;
	logic [CW-1:0]           cnt_q;
	logic [DW:0]             prem_q;
	logic [DW-1:0]           quo_q;
	logic [DW-1:0]           numer_q;
	ftf_pkg::unit_t          res_q [3];

	logic [MW-1:0]           any_mag;
	logic [MW-NB-1:0]        hi_bits;
	logic [2*NB-1:0]         sq;
	logic [RW-1:0]           trial;
	logic [DW:0]             prem_sh;

	always_comb begin
		any_mag = mag_q[0] | mag_q[1] | mag_q[2];
		hi_bits = any_mag[MW-1:NB];
		sq      = c_q[idx_q] * c_q[idx_q];
		trial   = root_q + rbit_q;
		prem_sh = {prem_q[DW-1:0], numer_q[DW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (hi_bits == '0) begin
						state_q <= S_SQ;
						idx_q   <= '0;
					end
				end
				S_SQ: begin
					if (idx_q == 2'd2) begin
						state_q <= S_ROOT;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				S_ROOT: begin
					if (rbit_q == '0) begin
						state_q <= (sum_q == '0) ? S_SAT : S_DIV;
						idx_q   <= '0;
						cnt_q   <= CW'(DW);
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_SAT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_SAT: begin
					if (idx_q == 2'd2 || sum_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
						idx_q   <= idx_q + 2'd1;
						cnt_q   <= CW'(DW);
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				neg_q    <= {vec_z[MW-1], vec_y[MW-1], vec_x[MW-1]};
				mag_q[0] <= vec_x[MW-1] ? MW'(-vec_x) : MW'(vec_x);
				mag_q[1] <= vec_y[MW-1] ? MW'(-vec_y) : MW'(vec_y);
				mag_q[2] <= vec_z[MW-1] ? MW'(-vec_z) : MW'(vec_z);
				sum_q    <= '0;
			end
			S_SHIFT: begin
				if (hi_bits == '0) begin
					c_q[0] <= mag_q[0][NB-1:0];
					c_q[1] <= mag_q[1][NB-1:0];
					c_q[2] <= mag_q[2][NB-1:0];
				end else begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end
			end
			S_SQ: begin
				sum_q <= sum_q + SW'(sq);
				if (idx_q == 2'd2) begin
					rem_q  <= {sum_q + SW'(sq), 12'd0};
					root_q <= '0;
					rbit_q <= RW'(1) << (RW - 2);
				end
			end
			S_ROOT: begin
				if (rbit_q != '0) begin
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= (root_q >> 1) + rbit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					rbit_q <= rbit_q >> 2;
				end else begin
					prem_q  <= '0;
					quo_q   <= '0;
					numer_q <= DW'(c_q[0]) << (ftf_pkg::OutFracBits + 6);
				end
			end
			S_DIV: begin
				if (cnt_q != '0) begin
					if (prem_sh >= (DW + 1)'(root_q[QW-1:0])) begin
						prem_q <= prem_sh - (DW + 1)'(root_q[QW-1:0]);
						quo_q  <= {quo_q[DW-2:0], 1'b1};
					end else begin
						prem_q <= prem_sh;
						quo_q  <= {quo_q[DW-2:0], 1'b0};
					end
					numer_q <= numer_q << 1;
				end else begin
					// Rounded quotient: floor((c*2^k + len/2)/len) from the remainder.
					quo_q <= quo_q + DW'((prem_q + (DW + 1)'(root_q[QW-1:1])
					         >= (DW + 1)'(root_q[QW-1:0])) ? 1 : 0);
				end
			end
			S_SAT: begin
				if (sum_q == '0) begin
					res_q[0] <= '0;
					res_q[1] <= '0;
					res_q[2] <= '0;
				end else begin
					if (neg_q[idx_q]) begin
						res_q[idx_q] <= (quo_q >= DW'(32768)) ? 16'sh8000 : -16'(quo_q);
					end else begin
						res_q[idx_q] <= (quo_q >= DW'(32767)) ? 16'sh7fff : 16'(quo_q);
					end
					prem_q  <= '0;
					quo_q   <= '0;
					numer_q <= (idx_q == 2'd0) ? DW'(c_q[1]) << (ftf_pkg::OutFracBits + 6)
					                           : DW'(c_q[2]) << (ftf_pkg::OutFracBits + 6);
				end
			end
			default: begin
			end
		endcase
	end

	assign done  = (state_q == S_DONE);
	assign out_x = res_q[0];
	assign out_y = res_q[1];
	assign out_z = res_q[2];

endmodule

[hdl/face_tangent_frame.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_tangent_frame: per-triangle tangent, binormal and normal unit vectors.
// Holds two vertices, forms the three frame vectors on the third and emits
// them in Q2.14 after normalization and a handedness fix.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  vtx       sink       pos_x/y/z, tex_u/v, signed Q16.16
//  frame     source     tangent, binormal, normal xyz, signed Q2.14
//
// The first two vertices of a triangle are stored as they arrive. The third
// starts the products through one 33x33 multiplier, then three passes of
// the shared normalizer (operand shift, square root and three divisions),
// then the handedness products. Reset clears the phase and the sequencer.
// The result waits in the output register until taken.
module face_tangent_frame (
	input  logic        clk,
	input  logic        arst_n,
	ftf_vertex_if.sink  vtx,
	ftf_frame_if.source frame
);

	localparam int unsigned DW = ftf_pkg::DiffWidth;
	localparam int unsigned PW = ftf_pkg::ProdWidth;
	localparam int unsigned VW = ftf_pkg::VecWidth;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_NRM  = 7'b0000100,
		S_WAIT = 7'b0001000,
		S_HAND = 7'b0010000,
		S_FIX  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [1:0]               phase_q;
	ftf_pkg::coord_t          pos_q [6];
	ftf_pkg::coord_t          tex_q [4];
	logic signed [DW-1:0]     e0_q [3];
	logic signed [DW-1:0]     e1_q [3];
	logic signed [DW-1:0]     du0_q, du1_q, dv0_q, dv1_q;
	logic signed [VW-1:0]     vec_q [9];
	logic signed [PW-1:0]     prod_q;
	logic [4:0]               step_q;
	logic [1:0]               nsel_q;
	ftf_pkg::unit_t           unit_q [9];
	logic signed [47:0]       dot_q;
	ftf_pkg::frame_t          out_q;
	logic                     out_valid_q;

	logic signed [DW-1:0]     ma, mb;
	logic signed [PW-1:0]     prod;
	logic                     n_start, n_done;
	ftf_pkg::unit_t           n_x, n_y, n_z;
	logic signed [VW-1:0]     nv_x, nv_y, nv_z;
	logic                     accept;
	logic signed [15:0]       ha, hb;
	logic signed [31:0]       hprod;
	logic [3:0]               vi;

	assign accept    = vtx.valid && vtx.ready;
	assign vtx.ready = (state_q == S_IDLE) && !out_valid_q;

	// Product schedule: pairs (a,b) for each vector term, subtracted pairwise.
	always_comb begin
		ma = '0;
		mb = '0;
		case (step_q)
			5'd0:  begin ma = e1_q[1]; mb = e0_q[2]; end
			5'd1:  begin ma = e1_q[2]; mb = e0_q[1]; end
			5'd2:  begin ma = e1_q[2]; mb = e0_q[0]; end
			5'd3:  begin ma = e1_q[0]; mb = e0_q[2]; end
			5'd4:  begin ma = e1_q[0]; mb = e0_q[1]; end
			5'd5:  begin ma = e1_q[1]; mb = e0_q[0]; end
			5'd6:  begin ma = e0_q[0]; mb = dv1_q; end
			5'd7:  begin ma = e1_q[0]; mb = dv0_q; end
			5'd8:  begin ma = e0_q[1]; mb = dv1_q; end
			5'd9:  begin ma = e1_q[1]; mb = dv0_q; end
			5'd10: begin ma = e0_q[2]; mb = dv1_q; end
			5'd11: begin ma = e1_q[2]; mb = dv0_q; end
			5'd12: begin ma = e0_q[0]; mb = du1_q; end
			5'd13: begin ma = e1_q[0]; mb = du0_q; end
			5'd14: begin ma = e0_q[1]; mb = du1_q; end
			5'd15: begin ma = e1_q[1]; mb = du0_q; end
			5'd16: begin ma = e0_q[2]; mb = du1_q; end
			5'd17: begin ma = e1_q[2]; mb = du0_q; end
			default: begin
			end
		endcase
		prod = ma * mb;
		vi   = 4'(step_q[4:1]);
	end

	// Handedness: cross(t, b) . n over six narrow products and three wide ones.
	always_comb begin
		ha = '0;
		hb = '0;
		case (step_q)
			5'd0: begin ha = unit_q[1]; hb = unit_q[5]; end
			5'd1: begin ha = unit_q[2]; hb = unit_q[4]; end
			5'd2: begin ha = unit_q[2]; hb = unit_q[3]; end
			5'd3: begin ha = unit_q[0]; hb = unit_q[5]; end
			5'd4: begin ha = unit_q[0]; hb = unit_q[4]; end
			5'd5: begin ha = unit_q[1]; hb = unit_q[3]; end
			default: begin
			end
		endcase
		hprod = ha * hb;
	end

	always_comb begin
		case (nsel_q)
			2'd0: begin
				nv_x = vec_q[0]; nv_y = vec_q[1]; nv_z = vec_q[2];
			end
			2'd1: begin
				nv_x = vec_q[3]; nv_y = vec_q[4]; nv_z = vec_q[5];
			end
			default: begin
				nv_x = vec_q[6]; nv_y = vec_q[7]; nv_z = vec_q[8];
			end
		endcase
	end

	assign n_start = (state_q == S_NRM);

	ftf_norm_unit u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (n_start),
		.vec_x  (nv_x),
		.vec_y  (nv_y),
		.vec_z  (nv_z),
		.done   (n_done),
		.out_x  (n_x),
		.out_y  (n_y),
		.out_z  (n_z)
	);

	logic signed [31:0] cross_q [3];
	logic signed [31:0] cur_cross;
	assign cur_cross = cross_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			step_q      <= '0;
			nsel_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (frame.valid && frame.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (phase_q == 2'd2) begin
							phase_q <= '0;
							state_q <= S_MUL;
							step_q  <= '0;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				S_MUL: begin
					if (step_q == 5'd18) begin
						state_q <= S_NRM;
						nsel_q  <= '0;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_NRM: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (n_done) begin
						if (nsel_q == 2'd2) begin
							state_q <= S_HAND;
							step_q  <= '0;
						end else begin
							nsel_q  <= nsel_q + 2'd1;
							state_q <= S_NRM;
						end
					end
				end
				S_HAND: begin
					if (step_q == 5'd9) begin
						state_q <= S_FIX;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_FIX: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (phase_q == 2'd2) begin
						e0_q[0] <= DW'(pos_q[0]) - DW'(pos_q[3]);
						e0_q[1] <= DW'(pos_q[1]) - DW'(pos_q[4]);
						e0_q[2] <= DW'(pos_q[2]) - DW'(pos_q[5]);
						e1_q[0] <= DW'(vtx.data.pos_x) - DW'(pos_q[0]);
						e1_q[1] <= DW'(vtx.data.pos_y) - DW'(pos_q[1]);
						e1_q[2] <= DW'(vtx.data.pos_z) - DW'(pos_q[2]);
						du0_q   <= DW'(tex_q[0]) - DW'(tex_q[2]);
						du1_q   <= DW'(vtx.data.tex_u) - DW'(tex_q[0]);
						dv0_q   <= DW'(tex_q[1]) - DW'(tex_q[3]);
						dv1_q   <= DW'(vtx.data.tex_v) - DW'(tex_q[1]);
					end else if (phase_q == 2'd0) begin
						pos_q[0] <= vtx.data.pos_x;
						pos_q[1] <= vtx.data.pos_y;
						pos_q[2] <= vtx.data.pos_z;
						tex_q[0] <= vtx.data.tex_u;
						tex_q[1] <= vtx.data.tex_v;
					end else begin
						pos_q[3] <= vtx.data.pos_x;
						pos_q[4] <= vtx.data.pos_y;
						pos_q[5] <= vtx.data.pos_z;
						tex_q[2] <= vtx.data.tex_u;
						tex_q[3] <= vtx.data.tex_v;
					end
				end
			end
			S_MUL: begin
				prod_q <= prod;
				if (step_q[0] == 1'b1) begin
					vec_q[vi] <= VW'(prod_q) - VW'(prod);
				end
			end
			S_WAIT: begin
				if (n_done) begin
					// Vector order: normal, tangent, binormal.
					case (nsel_q)
						2'd0: begin
							unit_q[6] <= n_x; unit_q[7] <= n_y; unit_q[8] <= n_z;
						end
						2'd1: begin
							unit_q[0] <= n_x; unit_q[1] <= n_y; unit_q[2] <= n_z;
						end
						default: begin
							unit_q[3] <= n_x; unit_q[4] <= n_y; unit_q[5] <= n_z;
						end
					endcase
				end
			end
			S_HAND: begin
				case (step_q)
					5'd0: cross_q[0] <= hprod;
					5'd1: cross_q[0] <= cross_q[0] - hprod;
					5'd2: cross_q[1] <= hprod;
					5'd3: cross_q[1] <= cross_q[1] - hprod;
					5'd4: cross_q[2] <= hprod;
					5'd5: cross_q[2] <= cross_q[2] - hprod;
					5'd6: dot_q <= 48'(cur_cross) * 48'(unit_q[6]);
					5'd7: dot_q <= dot_q + 48'(cross_q[1]) * 48'(unit_q[7]);
					5'd8: dot_q <= dot_q + 48'(cross_q[2]) * 48'(unit_q[8]);
					default: begin
					end
				endcase
			end
			S_FIX: begin
				out_q.binormal_x <= unit_q[3];
				out_q.binormal_y <= unit_q[4];
				out_q.binormal_z <= unit_q[5];
				out_q.normal_x   <= unit_q[6];
				out_q.normal_y   <= unit_q[7];
				out_q.normal_z   <= unit_q[8];
				if (dot_q[47]) begin
					out_q.tangent_x <= (unit_q[0] == 16'sh8000) ? 16'sh7fff : -unit_q[0];
					out_q.tangent_y <= (unit_q[1] == 16'sh8000) ? 16'sh7fff : -unit_q[1];
					out_q.tangent_z <= (unit_q[2] == 16'sh8000) ? 16'sh7fff : -unit_q[2];
				end else begin
					out_q.tangent_x <= unit_q[0];
					out_q.tangent_y <= unit_q[1];
					out_q.tangent_z <= unit_q[2];
				end
			end
			default: begin
			end
		endcase
	end

	assign frame.valid = out_valid_q;
	assign frame.data  = out_q;

endmodule

[tb/face_tangent_frame_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_tangent_frame_test: self-checking testbench for face_tangent_frame.
// Streams vertices in, computes each triangle's tangent, binormal and normal
// independently or from the table, and compares every frame it returns.
// A directed table comes first, then random triangles, most with bursts of idling.
// ----------------------------------------------------------------------------
module face_tangent_frame_test;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		ftf_pkg::coord_t px, py, pz, tu, tv;
		bit              typed;
		ftf_pkg::frame_t frm;
	} vertex_row_t;

	localparam ftf_pkg::coord_t One  = 32'sh0001_0000;
	localparam ftf_pkg::coord_t Big  = 32'sh7fff_ffff;
	localparam ftf_pkg::coord_t Tiny = 32'sh8000_0000;
	localparam ftf_pkg::frame_t NoFrame = '0;
	localparam ftf_pkg::frame_t FlatFrame = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};

	logic clk;
	logic arst_n;
	ftf_vertex_if vtx();
	ftf_frame_if  frame();

	face_tangent_frame dut (.clk(clk), .arst_n(arst_n), .vtx(vtx), .frame(frame));

	ftf_pkg::frame_t frame_queue[$];
	int              error_count = 0;
	int              vertex_count = 0;
	int              frame_count = 0;
	bit              idle_on = 1;
	ftf_pkg::coord_t held_pos[6];
	ftf_pkg::coord_t held_tex[4];
	int              phase = 0;
	vertex_row_t     rows[$];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [47:0] unit_vector(input wide_t vx, input wide_t vy, input wide_t vz);
		wide_t          v[3];
		logic [127:0]   mag[3];
		logic [63:0]    c[3];
		logic [63:0]    sum, len, q;
		ftf_pkg::unit_t o[3];
		int             top, s;
		v[0] = vx;
		v[1] = vy;
		v[2] = vz;
		top = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			for (int k = 127; k >= 0; k--) begin
				if (mag[i][k]) begin
					if (k + 1 > top) top = k + 1;
					break;
				end
			end
		end
		s = top > ftf_pkg::NormBits ? top - ftf_pkg::NormBits : 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = 64'(mag[i] >> s);
			sum += c[i] * c[i];
		end
		if (sum == 0) return '0;
		len = int_sqrt(sum << 12);
		for (int i = 0; i < 3; i++) begin
			q = ((c[i] << (ftf_pkg::OutFracBits + 6)) + (len >> 1)) / len;
			if (v[i] < 0) o[i] = q >= 32768 ? -16'sd32768 : -ftf_pkg::unit_t'(q);
			else o[i] = q >= 32767 ? 16'sd32767 : ftf_pkg::unit_t'(q);
		end
		return {o[0], o[1], o[2]};
	endfunction

	function automatic bit tangent_frame(input ftf_pkg::vertex_t in,
		output ftf_pkg::frame_t f);
		wide_t          e0[3], e1[3], p3[3], nv[3], tv[3], bv[3];
		wide_t          du0, du1, dv0, dv1;
		ftf_pkg::unit_t t[3], b[3], n[3];
		longint         cx, cy, cz, dot;
		f = '0;
		if (phase < 2) begin
			held_pos[phase*3]   = in.pos_x;
			held_pos[phase*3+1] = in.pos_y;
			held_pos[phase*3+2] = in.pos_z;
			held_tex[phase*2]   = in.tex_u;
			held_tex[phase*2+1] = in.tex_v;
			phase++;
			return 0;
		end
		phase = 0;
		p3[0] = in.pos_x;
		p3[1] = in.pos_y;
		p3[2] = in.pos_z;
		for (int i = 0; i < 3; i++) begin
			e0[i] = wide_t'(held_pos[i]) - wide_t'(held_pos[3+i]);
			e1[i] = p3[i] - wide_t'(held_pos[i]);
		end
		du0 = wide_t'(held_tex[0]) - wide_t'(held_tex[2]);
		du1 = wide_t'(in.tex_u) - wide_t'(held_tex[0]);
		dv0 = wide_t'(held_tex[1]) - wide_t'(held_tex[3]);
		dv1 = wide_t'(in.tex_v) - wide_t'(held_tex[1]);
		nv[0] = e1[1] * e0[2] - e1[2] * e0[1];
		nv[1] = e1[2] * e0[0] - e1[0] * e0[2];
		nv[2] = e1[0] * e0[1] - e1[1] * e0[0];
		for (int i = 0; i < 3; i++) begin
			tv[i] = e0[i] * dv1 - e1[i] * dv0;
			bv[i] = e0[i] * du1 - e1[i] * du0;
		end
		{n[0], n[1], n[2]} = unit_vector(nv[0], nv[1], nv[2]);
		{t[0], t[1], t[2]} = unit_vector(tv[0], tv[1], tv[2]);
		{b[0], b[1], b[2]} = unit_vector(bv[0], bv[1], bv[2]);
		cx = longint'(t[1]) * b[2] - longint'(t[2]) * b[1];
		cy = longint'(t[2]) * b[0] - longint'(t[0]) * b[2];
		cz = longint'(t[0]) * b[1] - longint'(t[1]) * b[0];
		dot = cx * n[0] + cy * n[1] + cz * n[2];
		if (dot < 0) begin
			for (int i = 0; i < 3; i++) t[i] = t[i] == -16'sd32768 ? 16'sd32767 : -t[i];
		end
		f = '{t[0], t[1], t[2], b[0], b[1], b[2], n[0], n[1], n[2]};
		return 1;
	endfunction

	task automatic send_vertex(input ftf_pkg::vertex_t v, input bit typed,
		input ftf_pkg::frame_t typed_frame);
		ftf_pkg::frame_t f;
		int              gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			vtx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx.valid <= 1'b1;
		vtx.data  <= v;
		do @(posedge clk); while (!vtx.ready);
		vertex_count++;
		if (tangent_frame(v, f)) begin
			if (typed) f = typed_frame;
			frame_queue = {frame_queue, f};
		end
	endtask

	function automatic ftf_pkg::coord_t random_coord();
		case ($urandom_range(0, 5)) inside
			[0:1]:   return ftf_pkg::coord_t'($urandom);
			2:       return $urandom_range(0, 1) ? Big : Tiny;
			3:       return ftf_pkg::coord_t'($signed($urandom_range(0, 8192)) - 4096);
			default: return ftf_pkg::coord_t'($signed($urandom_range(0, 32'h0080_0000))
				- 32'sh0040_0000);
		endcase
	endfunction

	task automatic wait_drained();
		while (frame_queue.size() != 0) @(posedge clk);
	endtask

	initial begin
		ftf_pkg::frame_t  nf;
		ftf_pkg::vertex_t v;
		nf = '0;
		rows = '{
			'{0, 0, 0, 0, 0, 0, NoFrame}, '{0, 0, 0, 0, 0, 0, NoFrame},
			'{0, 0, 0, 0, 0, 1, NoFrame},
			'{0, 0, 0, 0, 0, 0, NoFrame}, '{-One, 0, 0, -One, 0, 0, NoFrame},
			'{0, One, 0, 0, One, 1, FlatFrame},
			'{0, 0, 0, 0, 0, 0, NoFrame}, '{-One, 0, 0, -One, 0, 0, NoFrame},
			'{0, One, 0, 0, -One, 1, FlatFrame},
			'{Big, Big, Big, Big, Big, 0, NoFrame}, '{Tiny, Tiny, Tiny, Tiny, Tiny, 0, NoFrame},
			'{Tiny, Big, Tiny, Big, Tiny, 0, NoFrame},
			'{Tiny, Big, 0, Tiny, Big, 0, NoFrame}, '{Big, Tiny, Big, Big, Tiny, 0, NoFrame},
			'{0, Tiny, Big, Tiny, Tiny, 0, NoFrame},
			'{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
				0, NoFrame},
			'{32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
				0, NoFrame},
			'{-1, 1, -1, 1, -1, 0, NoFrame},
			'{0, 0, 0, 0, 0, 0, NoFrame}, '{One, One, One, One, 0, 0, NoFrame},
			'{2*One, 2*One, 2*One, 0, One, 0, NoFrame}
		};
		arst_n = 1'b0;
		vtx.valid = 1'b0;
		vtx.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			v = '{rows[i].px, rows[i].py, rows[i].pz, rows[i].tu, rows[i].tv};
			send_vertex(v, rows[i].typed, rows[i].frm);
		end
		vtx.valid <= 1'b0;
		wait_drained();
		for (int i = 0; i < 1330; i++) begin
			if (i == 600) begin
				vtx.valid <= 1'b0;
				wait_drained();
			end
			if (i == 1150) idle_on = 0;
			if (phase == 0 && $urandom_range(0, 9) == 0) begin
				v = '{random_coord(), random_coord(), random_coord(), 0, 0};
				v.tex_u = v.pos_x;
				v.tex_v = ftf_pkg::coord_t'($urandom);
			end else begin
				v = '{random_coord(), random_coord(), random_coord(), random_coord(),
					random_coord()};
			end
			send_vertex(v, 0, nf);
		end
		vtx.valid <= 1'b0;
		wait_drained();
		repeat (300) @(posedge clk);
		$display("Sent %0d vertices and checked %0d frames: directed extremes,", vertex_count,
			frame_count);
		$display("degenerate and mirrored triangles, then random triangles with idling.");
		if (error_count == 0 && frame_queue.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		int n;
		frame.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				frame.ready <= 1'b0;
				n = $urandom_range(1, 12);
			end else begin
				frame.ready <= 1'b1;
				n = $urandom_range(1, 20);
			end
			repeat (n) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		ftf_pkg::frame_t want, got;
		if (arst_n && frame.valid && frame.ready) begin
			got = frame.data;
			frame_count++;
			if (frame_queue.size() == 0) begin
				$display("%0t: unexpected frame transaction %h", $time, got);
				error_count++;
			end else begin
				want = frame_queue.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (want[143-16*k -: 16] !== got[143-16*k -: 16]) begin
						$display("%0t: field %0d expected %0d actual %0d", $time, k,
							$signed(want[143-16*k -: 16]), $signed(got[143-16*k -: 16]));
						error_count++;
					end
				end
			end
		end
	end

endmodule

[filelist.f]
hdl/ftf_pkg.sv
hdl/ftf_stream_if.sv
hdl/ftf_norm_unit.sv
hdl/face_tangent_frame.sv
tb/face_tangent_frame_test.sv
